### rtl/piecewise_linear_curve_eval_core_defines.svh
// ----------------------------------------------------------------------------
// Piecewise-linear curve evaluator: assertion macros
// Concurrent check helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_CURVE_EVAL_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_CURVE_EVAL_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PWLCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pwlce check failed");
// next-cycle implication
`define PWLCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pwlce check failed");
`else
`define PWLCE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PWLCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/pwlce_pkg.sv
// ----------------------------------------------------------------------------
// pwlce_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pwlce_pkg;

    localparam int DATA_W     = 16;
    localparam int MAX_POINTS = 16;
    localparam int PTR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 5;   // point_count register width
    localparam int IDX_W      = 4;   // point_index field width
    localparam int FRAC_W     = 16;  // Q0.16 fraction
    localparam int DIV_CNT_W  = $clog2(FRAC_W);
    localparam int REGION_W   = 2;

    localparam int S_TDATA_W  = 56;  // 52 bits of fields, padded to bytes
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 3;

    // command (tuser bit 0 on the slave side)
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // region codes
    localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd0;
    localparam logic [REGION_W-1:0] REGION_INTERP = 2'd1;
    localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

    typedef struct packed {
        logic write;      // store one breakpoint
        logic start;      // latch sample, reset scan pointer
        logic hold;       // result = held value, invalid
        logic take_below; // result = current y, below first point
        logic take_last;  // result = current y, at or past last point
        logic step;       // current point becomes previous, advance
        logic setup;      // prepare divide operands and dy
        logic div_step;   // one restoring divide step
        logic mul;        // fraction * |dy|
        logic add;        // prev_y +/- scaled delta
        logic commit;     // update held value from result
    } t_cmd;

    typedef struct packed {
        logic lt;         // sample < current x
        logic first;      // scan pointer at entry 0
        logic last;       // scan pointer at last entry in use
        logic div_done;   // this is the final divide step
    } t_status;

endpackage

`default_nettype wire

### rtl/pwlce_dpath.sv
// ----------------------------------------------------------------------------
// pwlce_dpath
// Breakpoint memory, scan registers, serial divider, multiplier, result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwlce_dpath (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire pwlce_pkg::t_cmd               i_cmd,
    input  wire        [pwlce_pkg::IDX_W-1:0]  i_point_index,
    input  wire signed [pwlce_pkg::DATA_W-1:0] i_point_x,
    input  wire signed [pwlce_pkg::DATA_W-1:0] i_point_y,
    input  wire signed [pwlce_pkg::DATA_W-1:0] i_sample,
    input  wire        [pwlce_pkg::CNT_W-1:0]  i_point_count,
    output pwlce_pkg::t_status                 o_status,
    output logic signed [pwlce_pkg::DATA_W-1:0] o_res_value,
    output logic                               o_res_valid,
    output logic       [pwlce_pkg::REGION_W-1:0] o_res_region
);
    import pwlce_pkg::*;

    // table entry: {y, x}
    logic [2*DATA_W-1:0]        r_mem [MAX_POINTS];
    logic [2*DATA_W-1:0]        r_rd;

    logic signed [DATA_W-1:0]   r_sample;
    logic [PTR_W-1:0]           r_idx;
    logic [PTR_W-1:0]           r_last;
    logic signed [DATA_W-1:0]   r_prev_x;
    logic signed [DATA_W-1:0]   r_prev_y;
    logic [DATA_W:0]            r_rem;
    logic [DATA_W-1:0]          r_den;
    logic [FRAC_W-1:0]          r_quo;
    logic [DIV_CNT_W-1:0]       r_div_cnt;
    logic [DATA_W-1:0]          r_mag;
    logic                       r_neg;
    logic [FRAC_W+DATA_W-1:0]   r_prod;
    logic signed [DATA_W-1:0]   r_res_value;
    logic                       r_res_valid;
    logic [REGION_W-1:0]        r_res_region;
    logic signed [DATA_W-1:0]   r_held;

    logic signed [DATA_W-1:0]   cur_x;
    logic signed [DATA_W-1:0]   cur_y;
    logic [PTR_W-1:0]           last_idx;
    logic signed [DATA_W:0]     num_w;
    logic signed [DATA_W:0]     den_w;
    logic signed [DATA_W:0]     dy_w;
    logic signed [DATA_W:0]     dy_abs;
    logic [DATA_W:0]            rem_sh;
    logic                       rem_ge;
    logic [DATA_W-1:0]          delta;

    assign cur_x = r_rd[DATA_W-1:0];
    assign cur_y = r_rd[2*DATA_W-1:DATA_W];

    // count of zero acts as one, above capacity saturates
    always_comb begin
        if (i_point_count == '0) begin
            last_idx = '0;
        end else if (i_point_count > CNT_W'(MAX_POINTS)) begin
            last_idx = PTR_W'(MAX_POINTS - 1);
        end else begin
            last_idx = PTR_W'(i_point_count - CNT_W'(1));
        end
    end

    assign num_w  = {r_sample[DATA_W-1], r_sample} - {r_prev_x[DATA_W-1], r_prev_x};
    assign den_w  = {cur_x[DATA_W-1], cur_x} - {r_prev_x[DATA_W-1], r_prev_x};
    assign dy_w   = {cur_y[DATA_W-1], cur_y} - {r_prev_y[DATA_W-1], r_prev_y};
    assign dy_abs = dy_w[DATA_W] ? -dy_w : dy_w;

    // remainder stays below the divisor, so the shift fits DATA_W+1 bits
    assign rem_sh = {r_rem[DATA_W-1:0], 1'b0};
    assign rem_ge = rem_sh >= {1'b0, r_den};
    assign delta  = r_prod[FRAC_W+DATA_W-1:FRAC_W];

    always_comb begin
        o_status.lt       = r_sample < cur_x;
        o_status.first    = r_idx == '0;
        o_status.last     = r_idx == r_last;
        o_status.div_done = r_div_cnt == '1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && (32'(i_point_index) < MAX_POINTS)) begin
            r_mem[PTR_W'(i_point_index)] <= {i_point_y, i_point_x};
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sample <= i_sample;
            r_idx    <= '0;
            r_last   <= last_idx;
        end
        if (i_cmd.step) begin
            r_prev_x <= cur_x;
            r_prev_y <= cur_y;
            r_idx    <= r_idx + PTR_W'(1);
        end
        if (i_cmd.setup) begin
            r_rem     <= {1'b0, num_w[DATA_W-1:0]};
            r_den     <= den_w[DATA_W-1:0];
            r_neg     <= dy_w[DATA_W];
            r_mag     <= dy_abs[DATA_W-1:0];
            r_quo     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= rem_ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo     <= {r_quo[FRAC_W-2:0], rem_ge};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= r_quo * r_mag;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.hold) begin
            r_res_value  <= r_held;
            r_res_valid  <= 1'b0;
            r_res_region <= REGION_BELOW;
        end else if (i_cmd.take_below) begin
            r_res_value  <= cur_y;
            r_res_valid  <= 1'b1;
            r_res_region <= REGION_BELOW;
        end else if (i_cmd.take_last) begin
            r_res_value  <= cur_y;
            r_res_valid  <= 1'b1;
            r_res_region <= REGION_ABOVE;
        end else if (i_cmd.add) begin
            r_res_value  <= r_neg ? (r_prev_y - $signed(delta))
                                  : (r_prev_y + $signed(delta));
            r_res_valid  <= 1'b1;
            r_res_region <= REGION_INTERP;
        end else begin
            r_res_value  <= r_res_value;
            r_res_valid  <= r_res_valid;
            r_res_region <= r_res_region;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.commit && r_res_valid) begin
            r_held <= r_res_value;
        end
    end

    assign o_res_value  = r_res_value;
    assign o_res_valid  = r_res_valid;
    assign o_res_region = r_res_region;

endmodule

`default_nettype wire

### rtl/pwlce_ctrl.sv
// ----------------------------------------------------------------------------
// pwlce_ctrl
// Sequencer: accept, table scan, divide, multiply, add, hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwlce_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    input  wire                      i_command,
    input  wire                      i_sample_valid,
    input  wire pwlce_pkg::t_status  i_status,
    input  wire                      i_out_free,
    output logic                     o_in_ready,
    output logic                     o_out_load,
    output pwlce_pkg::t_cmd          o_cmd
);
    import pwlce_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_ADD   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_ready = r_state == ST_IDLE;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_LOAD) begin
                        o_cmd.write = 1'b1;
                    end else if (!i_sample_valid) begin
                        o_cmd.hold = 1'b1;
                        n_state    = ST_DONE;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_FETCH;
                    end
                end
            end
            ST_FETCH: n_state = ST_CMP;
            ST_CMP: begin
                priority if (i_status.first && i_status.lt) begin
                    o_cmd.take_below = 1'b1;
                    n_state          = ST_DONE;
                end else if (i_status.lt) begin
                    o_cmd.setup = 1'b1;
                    n_state     = ST_DIV;
                end else if (i_status.last) begin
                    o_cmd.take_last = 1'b1;
                    n_state         = ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_FETCH;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_out_load   = 1'b1;
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/piecewise_linear_curve_eval_core.sv
// Piecewise-linear curve evaluator. Load transactions (tuser command = load)
// write one (x,y) breakpoint, signed Q8.8, into a 16-entry table and produce
// no output. Evaluate transactions map a sample through the curve and produce
// exactly one output transaction. An invalid sample returns the last valid
// result with result_valid low. A valid sample walks the table one entry at a
// time from entry 0, each entry a registered table read, then a compare; if it
// lands between two points, a restoring divider forms the Q0.16 fraction, then
// one multiply and one add follow. The output register lets the next
// transaction start while a result waits on the master side. The user must
// write point_count on the config channel only while the core is idle; the
// core itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "piecewise_linear_curve_eval_core_defines.svh"

module piecewise_linear_curve_eval_core (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // slave stream
    input  wire                                   i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [3:0] point_index, [19:4] point_x, [35:20] point_y, [51:36] sample,
    // [55:52] zero
    input  wire [pwlce_pkg::S_TDATA_W-1:0]        i_s_axis_tdata,
    // [0] command, [1] sample_valid
    input  wire [pwlce_pkg::S_TUSER_W-1:0]        i_s_axis_tuser,
    // master stream
    output logic                                  o_m_axis_tvalid,
    input  wire                                   i_m_axis_tready,
    // [15:0] curve_value
    output logic [pwlce_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    // [0] result_valid, [2:1] region
    output logic [pwlce_pkg::M_TUSER_W-1:0]       o_m_axis_tuser,
    // config: point_count
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [pwlce_pkg::CNT_W-1:0]            i_cfg_data
);
    import pwlce_pkg::*;

    // payload unpack
    logic                       in_command;
    logic                       in_sample_valid;
    logic [IDX_W-1:0]           in_point_index;
    logic signed [DATA_W-1:0]   in_point_x;
    logic signed [DATA_W-1:0]   in_point_y;
    logic signed [DATA_W-1:0]   in_sample;

    assign in_command      = i_s_axis_tuser[0];
    assign in_sample_valid = i_s_axis_tuser[1];
    assign in_point_index  = i_s_axis_tdata[IDX_W-1:0];
    assign in_point_x      = i_s_axis_tdata[IDX_W+DATA_W-1:IDX_W];
    assign in_point_y      = i_s_axis_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W];
    assign in_sample       = i_s_axis_tdata[IDX_W+3*DATA_W-1:IDX_W+2*DATA_W];

    // config register, always writable
    logic [CNT_W-1:0] r_point_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= CNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_point_count <= i_cfg_data;
        end
    end

    // controller <-> datapath
    t_cmd                     cmd;
    t_status                  status;
    logic                     out_load;
    logic                     out_free;
    logic signed [DATA_W-1:0] res_value;
    logic                     res_valid;
    logic [REGION_W-1:0]      res_region;

    pwlce_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_axis_tvalid),
        .i_command      (in_command),
        .i_sample_valid (in_sample_valid),
        .i_status       (status),
        .i_out_free     (out_free),
        .o_in_ready     (o_s_axis_tready),
        .o_out_load     (out_load),
        .o_cmd          (cmd)
    );

    pwlce_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_point_index  (in_point_index),
        .i_point_x      (in_point_x),
        .i_point_y      (in_point_y),
        .i_sample       (in_sample),
        .i_point_count  (r_point_count),
        .o_status       (status),
        .o_res_value    (res_value),
        .o_res_valid    (res_valid),
        .o_res_region   (res_region)
    );

    // output register: free when empty or being drained this cycle
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_value;
    logic                     r_out_flag;
    logic [REGION_W-1:0]      r_out_region;

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value  <= res_value;
            r_out_flag   <= res_valid;
            r_out_region <= res_region;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = {r_out_region, r_out_flag};

    // checks
    // a held (invalid) result always reports the below-first region
    `PWLCE_ASSERT_IMPL(a_held_region, i_clk, i_rst_n,
        (o_m_axis_tvalid && !o_m_axis_tuser[0]), (o_m_axis_tuser[2:1] == REGION_BELOW))
    // region code 3 is never produced
    `PWLCE_ASSERT_IMPL(a_region_legal, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tuser[2:1] != 2'd3))
    // a load never creates an output transaction
    `PWLCE_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready && (in_command == CMD_LOAD) && !o_m_axis_tvalid), !o_m_axis_tvalid)
    // an accepted evaluate, valid or not, leaves the core busy in the next cycle
    `PWLCE_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready && (in_command == CMD_EVAL)), !o_s_axis_tready)

endmodule

`default_nettype wire

### test/tb_piecewise_linear_curve_eval_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_curve_eval_core
// Self-checking bench for the breakpoint-table curve evaluator. A directed
// table covers reset state, range extremes and each corner of the scan, then
// random phases reload the table, change point_count while idle and stream
// load/evaluate transactions with random idling on both sides. Every result
// is checked field by field against typed-in rows or an in-bench curve model.
// ----------------------------------------------------------------------------

module tb_piecewise_linear_curve_eval_core;

    import pwlce_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no transaction at all
    localparam int SETTLE_CYCLES   = 60;    // idle wait after the result queue drains
    localparam int PRESSURE_CYCLES = 400;
    localparam int NUM_PHASES      = 12;
    localparam int PHASE_ITEMS     = 100;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     valid;
        logic [REGION_W-1:0]      region;
    } t_curve_result;

    typedef struct packed {
        logic                     cmd;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] smp;
        logic                     smp_valid;
        logic                     checked;   // expectation typed in the table
        t_curve_result            exp;
    } t_stream_item;

    typedef enum int {ROW_CFG, ROW_LOAD, ROW_EVAL} t_row_kind;

    typedef struct {
        t_row_kind     kind;
        int            arg0;   // cfg: count; load: index; eval: sample
        int            arg1;   // load: x; eval: sample_valid
        int            arg2;   // load: y
        logic          checked;
        t_curve_result exp;
    } t_dir_row;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    wire                  s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    wire                  m_tvalid;
    logic                 m_tready = 1'b0;
    wire  [M_TDATA_W-1:0] m_tdata;
    wire  [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    wire                  cfg_ready;
    logic [CNT_W-1:0]     cfg_data = '0;

    // side info that travels with the transaction currently offered
    logic                 item_checked = 1'b0;
    t_curve_result        item_exp = '0;

    piecewise_linear_curve_eval_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    wire s_acc   = s_tvalid && s_tready;
    wire m_acc   = m_tvalid && m_tready;
    wire cfg_acc = cfg_valid && cfg_ready;

    // ------------------------------------------------------------------------
    // Curve model state: breakpoint table, count register, held output
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0] bp_x [MAX_POINTS];
    logic signed [DATA_W-1:0] bp_y [MAX_POINTS];
    logic [CNT_W-1:0]         point_count_q = 5'd1;
    logic signed [DATA_W-1:0] held_curve = '0;

    t_curve_result expected_curve_q [$];

    int  error_count = 0;
    int  n_loads = 0;
    int  n_evals = 0;
    int  n_held = 0;
    int  n_cfg = 0;
    int  n_region [3] = '{0, 0, 0};
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  no_idle = 1'b0;
    bit  pressure_req = 1'b0;

    // Effective number of points: zero reads as one, anything past the
    // table size saturates.
    function automatic int points_in_use();
        int n;
        n = int'(point_count_q);
        if (n == 0) n = 1;
        if (n > MAX_POINTS) n = MAX_POINTS;
        return n;
    endfunction

    // Maps one sample through the current table. Does not touch held_curve.
    function automatic t_curve_result predict_curve(logic signed [DATA_W-1:0] smp,
                                                    logic smp_valid);
        t_curve_result r;
        int     n;
        int     i;
        bit     found;
        longint num, den, frac, dy, mag, t, v;
        r.value  = held_curve;
        r.valid  = 1'b0;
        r.region = REGION_BELOW;
        if (!smp_valid) return r;
        n       = points_in_use();
        r.valid = 1'b1;
        if (smp < bp_x[0]) begin
            r.value  = bp_y[0];
            r.region = REGION_BELOW;
        end else begin
            r.value  = bp_y[n-1];
            r.region = REGION_ABOVE;
            found    = 1'b0;
            for (i = 1; i < n; i++) begin
                if (!found && smp < bp_x[i]) begin
                    // scan guarantees bp_x[i-1] <= smp < bp_x[i], so den > 0
                    num  = longint'(smp) - longint'(bp_x[i-1]);
                    den  = longint'(bp_x[i]) - longint'(bp_x[i-1]);
                    frac = (num << FRAC_W) / den;
                    dy   = longint'(bp_y[i]) - longint'(bp_y[i-1]);
                    mag  = (dy < 0) ? -dy : dy;
                    t    = (frac * mag) >>> FRAC_W;
                    v    = (dy < 0) ? longint'(bp_y[i-1]) - t : longint'(bp_y[i-1]) + t;
                    r.value  = v[DATA_W-1:0];
                    r.region = REGION_INTERP;
                    found    = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: model update on every accepted input, compare on every output
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_curve_result want;
        t_curve_result pred;
        if (rst_n) begin
            if (m_acc) begin
                if (expected_curve_q.size() == 0) begin
                    $error("unexpected result transaction: curve_value %0d tuser %b",
                           $signed(m_tdata), m_tuser);
                    error_count++;
                end else begin
                    want = expected_curve_q.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("curve_value: expected %0d, actual %0d",
                               want.value, $signed(m_tdata));
                        error_count++;
                    end
                    if (m_tuser[0] !== want.valid) begin
                        $error("result_valid: expected %0d, actual %0d",
                               want.valid, m_tuser[0]);
                        error_count++;
                    end
                    if (m_tuser[2:1] !== want.region) begin
                        $error("region: expected %0d, actual %0d",
                               want.region, m_tuser[2:1]);
                        error_count++;
                    end
                end
            end
            if (s_acc) begin
                if (s_tuser[0] == CMD_LOAD) begin
                    bp_x[s_tdata[3:0]] = s_tdata[19:4];
                    bp_y[s_tdata[3:0]] = s_tdata[35:20];
                    n_loads++;
                end else begin
                    pred = predict_curve(s_tdata[51:36], s_tuser[1]);
                    // typed-in rows are checked against the table, not the model
                    want = item_checked ? item_exp : pred;
                    expected_curve_q.push_back(want);
                    if (pred.valid) held_curve = pred.value;
                    else n_held++;
                    if (pred.valid) n_region[pred.region]++;
                    n_evals++;
                end
            end
            if (cfg_acc) point_count_q = cfg_data;
        end
    end

    // Watchdog: stop if nothing at all moves for too long
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (s_acc || m_acc || cfg_acc) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL piecewise_linear_curve_eval_core");
        $finish;
    end

    // Idle length: mostly short, now and then long
    function automatic int pick_stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 99) < 55) return 0;
        return pick_stall_len();
    endfunction

    // ------------------------------------------------------------------------
    // Result receiver with random back-pressure and one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge clk);
            if (pressure_req) begin
                pressure_req = 1'b0;
                m_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge clk);
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 99) < 30) begin
                m_tready <= 1'b0;
                stall_left = pick_stall_len() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one transaction, return at the edge where it is taken. Valid
    // stays high into the next item when there is no gap.
    task automatic send_item(input t_stream_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid     <= 1'b1;
        s_tdata      <= {4'b0000, it.smp, it.py, it.px, it.idx};
        s_tuser      <= {it.smp_valid, it.cmd};
        item_checked <= it.checked;
        item_exp     <= it.exp;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // point_count changes only with the core drained and settled
    task automatic set_point_count(input int cnt);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_curve_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cnt[CNT_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // unused fields still carry random bits
    function automatic t_stream_item mk_load(int idx, int x, int y);
        t_stream_item it;
        it           = '0;
        it.cmd       = CMD_LOAD;
        it.idx       = idx[IDX_W-1:0];
        it.px        = x[DATA_W-1:0];
        it.py        = y[DATA_W-1:0];
        it.smp       = DATA_W'($urandom);
        it.smp_valid = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_stream_item mk_eval(int smp, int smp_valid);
        t_stream_item it;
        it           = '0;
        it.cmd       = CMD_EVAL;
        it.idx       = IDX_W'($urandom);
        it.px        = DATA_W'($urandom);
        it.py        = DATA_W'($urandom);
        it.smp       = smp[DATA_W-1:0];
        it.smp_valid = smp_valid[0];
        return it;
    endfunction

    function automatic t_dir_row drow(t_row_kind kind, int a0, int a1, int a2,
                                      logic chk, int ev, int evld, int ereg);
        t_dir_row r;
        r.kind       = kind;
        r.arg0       = a0;
        r.arg1       = a1;
        r.arg2       = a2;
        r.checked    = chk;
        r.exp.value  = ev[DATA_W-1:0];
        r.exp.valid  = evld[0];
        r.exp.region = ereg[REGION_W-1:0];
        return r;
    endfunction

    // Reload all slots with ascending x; narrow packs them into a small window
    task automatic load_sorted_table(input bit narrow);
        int xs [$];
        int base;
        int i;
        base = int'($urandom_range(0, 65535 - 300)) - 32768;
        for (i = 0; i < MAX_POINTS; i++) begin
            if (narrow) xs.push_back(base + int'($urandom_range(0, 300)));
            else xs.push_back(int'($urandom_range(0, 65535)) - 32768);
        end
        xs.sort();
        for (i = 0; i < MAX_POINTS; i++)
            send_item(mk_load(i, xs[i], int'($urandom_range(0, 65535)) - 32768));
    endtask

    function automatic t_stream_item random_item();
        int     r;
        int     k;
        longint lo, hi;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            // stray load, usually breaks the ordering
            return mk_load($urandom_range(0, 15), $urandom, $urandom);
        end
        if (r < 20) return mk_eval($urandom, 0);
        if (r < 40) begin
            // on or right beside a breakpoint
            k = $urandom_range(0, MAX_POINTS - 1);
            return mk_eval(int'(bp_x[k]) + int'($urandom_range(0, 2)) - 1, 1);
        end
        if (r < 55) return mk_eval($urandom, 1);
        lo = bp_x[0];
        hi = bp_x[points_in_use() - 1];
        if (hi > lo) return mk_eval(int'(lo + $urandom_range(0, int'(hi - lo))), 1);
        return mk_eval($urandom, 1);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    t_dir_row directed_tbl [$];
    int       count_list [9] = '{16, 1, 2, 31, 0, 16, 17, 3, 8};

    initial begin
        t_stream_item it;
        int           ph;
        int           sent;
        int           i;

        // after reset: invalid sample returns the zero held value
        directed_tbl.push_back(drow(ROW_EVAL, 32767, 0, 0, 1, 0, 0, REGION_BELOW));
        directed_tbl.push_back(drow(ROW_LOAD, 0, -32768, 32767, 0, 0, 0, 0));
        // one point in use, sample equal to its x: at or past last
        directed_tbl.push_back(drow(ROW_EVAL, -32768, 1, 0, 1, 32767, 1, REGION_ABOVE));
        directed_tbl.push_back(drow(ROW_LOAD, 1, -28399, -32768, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 2, -24030, 0, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 3, -19661, 256, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 4, -15292, -256, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 5, -10923, 32767, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 6, -6554, 32767, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 7, -2185, -32768, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 8, 2184, 100, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 9, 6553, -100, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 10, 10922, 1, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 11, 15291, 0, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 12, 19660, -1, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 13, 24029, 12345, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 14, 28398, -12345, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 15, 32767, -32768, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_CFG, 16, 0, 0, 0, 0, 0, 0));
        // start of the first segment: zero fraction gives the first y
        directed_tbl.push_back(drow(ROW_EVAL, -32768, 1, 0, 1, 32767, 1, REGION_INTERP));
        directed_tbl.push_back(drow(ROW_EVAL, 32767, 1, 0, 1, -32768, 1, REGION_ABOVE));
        directed_tbl.push_back(drow(ROW_EVAL, 32766, 1, 0, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_EVAL, -10923, 1, 0, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_EVAL, -1, 0, 0, 0, 0, 0, 0));
        // zero count behaves as one point
        directed_tbl.push_back(drow(ROW_CFG, 0, 0, 0, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_EVAL, 0, 1, 0, 1, 32767, 1, REGION_ABOVE));
        // count past the table size saturates; then a sample below the first point
        directed_tbl.push_back(drow(ROW_CFG, 31, 0, 0, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_LOAD, 0, -32000, -5, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_EVAL, -32768, 1, 0, 1, -5, 1, REGION_BELOW));
        // out-of-order breakpoint in the middle of the table
        directed_tbl.push_back(drow(ROW_LOAD, 8, -30000, 777, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_EVAL, 20000, 1, 0, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_CFG, 2, 0, 0, 0, 0, 0, 0));
        directed_tbl.push_back(drow(ROW_EVAL, -31000, 1, 0, 0, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < directed_tbl.size(); i++) begin
            case (directed_tbl[i].kind)
                ROW_CFG: begin
                    set_point_count(directed_tbl[i].arg0);
                end
                ROW_LOAD: begin
                    send_item(mk_load(directed_tbl[i].arg0, directed_tbl[i].arg1,
                                      directed_tbl[i].arg2));
                end
                default: begin
                    it         = mk_eval(directed_tbl[i].arg0, directed_tbl[i].arg1);
                    it.checked = directed_tbl[i].checked;
                    it.exp     = directed_tbl[i].exp;
                    send_item(it);
                end
            endcase
        end

        // random phases: new count, usually a fresh ascending table, then traffic
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            set_point_count((ph < 9) ? count_list[ph] : $urandom_range(0, 31));
            no_idle = (ph % 4 == 2);
            if (ph == 3) pressure_req = 1'b1;  // long output stall fills the core
            sent = 0;
            if ($urandom_range(0, 9) < 7) begin
                load_sorted_table($urandom_range(0, 3) == 0);
                sent = MAX_POINTS;
            end
            while (sent < PHASE_ITEMS) begin
                send_item(random_item());
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_curve_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d loads, %0d evaluations: %0d held, %0d below, %0d interp, %0d above",
                 n_loads, n_evals, n_held, n_region[0], n_region[1], n_region[2]);
        $display("over %0d point_count writes, with one %0d-cycle output hold-off",
                 n_cfg, PRESSURE_CYCLES);
        if (error_count == 0) begin
            $display("PASS piecewise_linear_curve_eval_core");
        end else begin
            $display("FAIL piecewise_linear_curve_eval_core");
        end
        $finish;
    end

endmodule

### piecewise_linear_curve_eval_core.f
+incdir+rtl
rtl/pwlce_pkg.sv
rtl/pwlce_dpath.sv
rtl/pwlce_ctrl.sv
rtl/piecewise_linear_curve_eval_core.sv
test/tb_piecewise_linear_curve_eval_core.sv
